// ===== hw/rtl/bst_pkg.sv =====
// Shared request, result and cell-chain types and codes for the bounded set table.
`timescale 1ns / 1ps
`default_nettype none

package bst_pkg;

    localparam int VAL_W = 32;
    localparam int CNT_W = 7;
    localparam int POS_W = 6;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_SEARCH = 2'd2;
    localparam logic [1:0] KIND_READ   = 2'd3;

    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_PRESENT = 3'd1;
    localparam logic [2:0] ST_ABSENT  = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;
    localparam logic [2:0] ST_RANGE   = 3'd5;

    typedef struct packed {
        logic [1:0]       kind;
        logic [VAL_W-1:0] item_value;
        logic [POS_W-1:0] position;
    } t_req;

    typedef struct packed {
        logic [2:0]       status;
        logic             found;
        logic [VAL_W-1:0] entry_out;
        logic [CNT_W-1:0] count;
    } t_rsp;

    typedef struct packed {
        logic capture;
        logic shift;
        logic append;
    } t_cell_ctl;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] rdata;
    } t_chain;

endpackage

`default_nettype wire

// ===== hw/rtl/bst_cell.sv =====
// One storage cell of the set table: holds an entry, compares it and shifts it down.
`timescale 1ns / 1ps
`default_nettype none

module bst_cell #(
    parameter int IDX = 0,
    parameter int SB  = 32,
    parameter int CW  = 7
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire bst_pkg::t_cell_ctl i_ctl,
    input  wire logic [SB-1:0]      i_cmp_value,
    input  wire logic [SB-1:0]      i_wr_value,
    input  wire logic [bst_pkg::POS_W-1:0] i_position,
    input  wire logic [CW-1:0]      i_count,
    input  wire logic [SB-1:0]      i_next_entry,
    input  wire bst_pkg::t_chain    i_chain,
    output bst_pkg::t_chain         o_chain,
    output logic [SB-1:0]           o_entry
);
    import bst_pkg::*;

    localparam int IW = (CW > POS_W) ? CW : POS_W;

    logic [SB-1:0] r_entry;
    logic          r_match;
    logic          r_sel;
    logic          live;

    assign live = CW'(IDX) < i_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
            r_sel   <= 1'b0;
        end else if (i_ctl.capture) begin
            r_match <= live && (r_entry == i_cmp_value);
            r_sel   <= live && (IW'(i_position) == IW'(IDX));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift && (i_chain.hit || r_match)) begin
            r_entry <= i_next_entry;
        end else if (i_ctl.append && (i_count == CW'(IDX))) begin
            r_entry <= i_wr_value;
        end
    end

    assign o_chain.hit   = i_chain.hit | r_match;
    assign o_chain.rdata = i_chain.rdata | (r_sel ? VAL_W'(r_entry) : {VAL_W{1'b0}});
    assign o_entry       = r_entry;

endmodule

`default_nettype wire

// ===== hw/rtl/bounded_set_table_unit.sv =====
// Top level of the bounded set table: request handling, cell chain and result register.
//
//  channel  direction  handshake                   payload
//  in       request    i_in_valid / o_in_ready     i_in_req  (bst_pkg::t_req)
//  out      result     o_out_valid / i_out_ready   o_out_rsp (bst_pkg::t_rsp)
//
// Each request has an accept cycle, in which every cell compares its entry with the
// value and its index with the position, and a commit cycle, in which the match flags
// ripple along the cell chain, the store shifts or appends and the result loads.
// Reset clears the count and the handshake state; entries hold whatever they held.
// A result waiting in the output register does not block the next request; the
// commit cycle of that request waits until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module bounded_set_table_unit #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire bst_pkg::t_req i_in_req,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output bst_pkg::t_rsp      o_out_rsp
);
    import bst_pkg::*;

    localparam int SB = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CW > POS_W) ? CW : POS_W;

    logic            r_busy;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    t_req            r_req;
    logic            r_out_valid;
    t_rsp            r_out;
    t_rsp            n_out;

    logic            accept;
    logic            go;
    logic            hit;
    logic            full;
    t_cell_ctl       ctl;
    t_chain          chain [CAPACITY+1];
    logic [SB-1:0]   entry [CAPACITY];
    logic [SB-1:0]   cmp_value;
    logic [SB-1:0]   wr_value;

    assign accept     = i_in_valid && !r_busy;
    assign go         = r_busy && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_busy;
    assign hit        = chain[CAPACITY].hit;
    assign full       = r_count == CW'(CAPACITY);
    assign cmp_value  = SB'(i_in_req.item_value);
    assign wr_value   = SB'(r_req.item_value);

    assign ctl.capture = accept;
    assign ctl.shift   = go && (r_req.kind == KIND_REMOVE);
    assign ctl.append  = go && (r_req.kind == KIND_ADD) && !hit && !full;

    assign chain[0].hit   = 1'b0;
    assign chain[0].rdata = {VAL_W{1'b0}};

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [SB-1:0] next_entry;
        if (g == CAPACITY - 1) begin : g_last
            assign next_entry = entry[g];
        end else begin : g_mid
            assign next_entry = entry[g+1];
        end
        bst_cell #(
            .IDX (g),
            .SB  (SB),
            .CW  (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_cmp_value  (cmp_value),
            .i_wr_value   (wr_value),
            .i_position   (i_in_req.position),
            .i_count      (r_count),
            .i_next_entry (next_entry),
            .i_chain      (chain[g]),
            .o_chain      (chain[g+1]),
            .o_entry      (entry[g])
        );
    end

    always_comb begin
        n_count         = r_count;
        n_out.status    = ST_DONE;
        n_out.found     = hit;
        n_out.entry_out = {VAL_W{1'b0}};
        unique case (r_req.kind)
            KIND_ADD: begin
                if (hit) begin
                    n_out.status = ST_PRESENT;
                end else if (full) begin
                    n_out.status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            KIND_REMOVE: begin
                if (r_count == '0) begin
                    n_out.status = ST_EMPTY;
                end else if (!hit) begin
                    n_out.status = ST_ABSENT;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            KIND_SEARCH: begin
                n_out.status = hit ? ST_DONE : ST_ABSENT;
            end
            KIND_READ: begin
                n_out.found = 1'b0;
                if (IW'(r_req.position) < IW'(r_count)) begin
                    n_out.entry_out = chain[CAPACITY].rdata;
                end else begin
                    n_out.status = ST_RANGE;
                end
            end
        endcase
        n_out.count = CNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (go) begin
                r_busy <= 1'b0;
            end
            if (go) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_in_req;
        end
        if (go) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

endmodule

`default_nettype wire

// ===== hw/rtl/bst_checker.sv =====
// Port-level assertions for the bounded set table and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bst_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_ready,
    input wire bst_pkg::t_req i_in_req,
    input wire logic          o_out_valid,
    input wire logic          i_out_ready,
    input wire bst_pkg::t_rsp o_out_rsp
);
    import bst_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_rsp))
        else $error("A stalled result changed or was dropped.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("A new request was taken while one was in work.");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_rsp.status == ST_EMPTY)
        |-> (o_out_rsp.count == '0) && !o_out_rsp.found)
        else $error("An empty status came with a nonzero count or a hit.");

    a_entry_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_rsp.entry_out != '0)
        |-> (o_out_rsp.status == ST_DONE) && !o_out_rsp.found)
        else $error("Entry data came with a request other than a good read.");

    a_found_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_rsp.found
        |-> (o_out_rsp.status == ST_DONE) || (o_out_rsp.status == ST_PRESENT))
        else $error("A hit came with a failing status.");

endmodule

bind bounded_set_table_unit bst_checker u_bst_checker (.*);

`default_nettype wire
